// File: sv/assert_macros.svh
// Assertion helpers clocked on aclk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AHT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define AHT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/aht_pkg.sv
`timescale 1ns / 1ps

package aht_pkg;

    localparam int BUCKETS   = 1024;
    localparam int WAYS      = 4;
    localparam int SLOTS     = BUCKETS * WAYS;
    localparam int BUCKET_W  = $clog2(BUCKETS);
    localparam int WAY_W     = $clog2(WAYS);
    localparam int ADDR_W    = 48;
    localparam int COUNT_W   = 32;
    localparam int IDX_W     = 12;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic CMD_COUNT = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] count;
    } entry_t;

    typedef entry_t [WAYS-1:0] row_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] count;
        logic               valid;
        logic               was_new;
        logic               bucket_full;
        logic               saturated;
    } result_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

endpackage

// File: sv/aht_ram.sv
`timescale 1ns / 1ps

module aht_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/aht_update.sv
`timescale 1ns / 1ps

module aht_update (
    input  aht_pkg::row_t                     row,
    input  logic                              command,
    input  logic [aht_pkg::ADDR_W-1:0]        address,
    input  logic [aht_pkg::WAY_W-1:0]         way,
    input  logic                              in_range,
    output aht_pkg::row_t                     new_row,
    output logic                              we,
    output aht_pkg::result_t                  result
);

    logic                        hit_found;
    logic                        free_found;
    logic [aht_pkg::WAY_W-1:0]   hit_way;
    logic [aht_pkg::WAY_W-1:0]   free_way;
    logic [aht_pkg::WAY_W-1:0]   sel_way;
    aht_pkg::entry_t             sel;
    aht_pkg::entry_t             rd;
    logic [aht_pkg::COUNT_W-1:0] base_count;
    logic                        sat;

    // Pick the first matching way and the first free way.
    always_comb begin
        hit_found  = 1'b0;
        free_found = 1'b0;
        hit_way    = '0;
        free_way   = '0;
        for (int w = 0; w < aht_pkg::WAYS; w++) begin
            if (row[w].valid) begin
                if (!hit_found && row[w].addr == address) begin
                    hit_found = 1'b1;
                    hit_way   = aht_pkg::WAY_W'(w);
                end
            end else if (!free_found) begin
                free_found = 1'b1;
                free_way   = aht_pkg::WAY_W'(w);
            end
        end
    end

    always_comb begin
        sel_way    = hit_found ? hit_way : free_way;
        base_count = hit_found ? row[sel_way].count : '0;
        sat        = (base_count == aht_pkg::COUNT_MAX);
        sel.valid  = 1'b1;
        sel.addr   = address;
        sel.count  = sat ? base_count : base_count + 1'b1;
        rd         = row[way];

        new_row = row;
        we      = 1'b0;
        result  = '0;

        if (command == aht_pkg::CMD_READ) begin
            if (in_range && rd.valid) begin
                result.addr      = rd.addr;
                result.count     = rd.count;
                result.valid     = 1'b1;
                result.saturated = (rd.count == aht_pkg::COUNT_MAX);
            end
        end else if (hit_found || free_found) begin
            new_row[sel_way] = sel;
            we               = 1'b1;
            result.addr      = address;
            result.count     = sel.count;
            result.valid     = 1'b1;
            result.was_new   = !hit_found;
            result.saturated = sat;
        end else begin
            result.bucket_full = 1'b1;
        end
    end

endmodule

// File: sv/address_hit_counter_table.sv
// A result is registered in the lookup state once the output register is free; no new
// input is taken during a lookup. Each item reads its bucket row from the table memory
// (registered read); a count with a hit or free way writes the row back in lookup.
// A new input is taken while the previous result still waits; its lookup then holds.
// Reset: synchronous, active low; afterward a sweep of all BUCKETS (1024) addresses
// clears every bucket row, with s_ready low until it ends.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module address_hit_counter_table (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_command,
    input  logic [aht_pkg::ADDR_W-1:0]        s_address,
    input  logic [aht_pkg::IDX_W-1:0]         s_slot_index,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [aht_pkg::ADDR_W-1:0]        m_entry_address,
    output logic [aht_pkg::COUNT_W-1:0]       m_entry_count,
    output logic                              m_entry_valid,
    output logic                              m_was_new,
    output logic                              m_bucket_full,
    output logic                              m_count_saturated
);

    aht_pkg::state_t                 state_reg, state_next;
    logic [aht_pkg::BUCKET_W-1:0]    clr_reg, clr_next;
    logic                            m_valid_reg, m_valid_next;
    aht_pkg::result_t                result_reg, result_next;

    logic                            cmd_reg;
    logic [aht_pkg::ADDR_W-1:0]      addr_reg;
    logic [aht_pkg::BUCKET_W-1:0]    bucket_reg;
    logic [aht_pkg::WAY_W-1:0]       way_reg;
    logic                            in_range_reg;

    logic                            accept;
    logic [aht_pkg::BUCKET_W-1:0]    rd_bucket;
    logic                            mem_we;
    logic [aht_pkg::BUCKET_W-1:0]    mem_waddr;
    aht_pkg::row_t                   mem_wdata;
    aht_pkg::row_t                   mem_rdata;
    aht_pkg::row_t                   upd_row;
    logic                            upd_we;
    aht_pkg::result_t                upd_result;

    assign accept    = s_valid && s_ready;
    assign rd_bucket = (s_command == aht_pkg::CMD_READ)
                     ? aht_pkg::BUCKET_W'(s_slot_index / aht_pkg::WAYS)
                     : aht_pkg::BUCKET_W'(s_address % aht_pkg::BUCKETS);

    aht_ram #(
        .DATA_W ($bits(aht_pkg::row_t)),
        .ADDR_W (aht_pkg::BUCKET_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (rd_bucket),
        .rdata (mem_rdata)
    );

    aht_update u_update (
        .row      (mem_rdata),
        .command  (cmd_reg),
        .address  (addr_reg),
        .way      (way_reg),
        .in_range (in_range_reg),
        .new_row  (upd_row),
        .we       (upd_we),
        .result   (upd_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= aht_pkg::ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the item fields for the lookup cycle.
    always_ff @(posedge aclk) begin
        result_reg <= result_next;
        if (accept) begin
            cmd_reg      <= s_command;
            addr_reg     <= s_address;
            bucket_reg   <= rd_bucket;
            way_reg      <= aht_pkg::WAY_W'(s_slot_index % aht_pkg::WAYS);
            in_range_reg <= (32'(s_slot_index) < aht_pkg::SLOTS);
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        m_valid_next = m_valid_reg;
        result_next  = result_reg;
        s_ready      = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = bucket_reg;
        mem_wdata    = upd_row;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            aht_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == aht_pkg::BUCKET_W'(aht_pkg::BUCKETS - 1)) begin
                    state_next = aht_pkg::ST_IDLE;
                end
            end
            aht_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = aht_pkg::ST_LOOKUP;
                end
            end
            aht_pkg::ST_LOOKUP: begin
                // Hold the row read until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    mem_we       = upd_we;
                    result_next  = upd_result;
                    m_valid_next = 1'b1;
                    state_next   = aht_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = aht_pkg::ST_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    assign m_valid           = m_valid_reg;
    assign m_entry_address   = result_reg.addr;
    assign m_entry_count     = result_reg.count;
    assign m_entry_valid     = result_reg.valid;
    assign m_was_new         = result_reg.was_new;
    assign m_bucket_full     = result_reg.bucket_full;
    assign m_count_saturated = result_reg.saturated;

    `AHT_ASSERT_NOW(a_ready_idle, s_ready, state_reg == aht_pkg::ST_IDLE, "ready outside idle")
    `AHT_ASSERT_NXT(a_accept_lookup, s_valid && s_ready, state_reg == aht_pkg::ST_LOOKUP, "no lookup")
    `AHT_ASSERT_NXT(a_lookup_result, (state_reg == aht_pkg::ST_LOOKUP) && (!m_valid || m_ready), m_valid, "no result")
    `AHT_ASSERT_NOW(a_full_clean, m_valid && m_bucket_full, !m_entry_valid && !m_was_new, "dropped item flagged")

endmodule

// File: test/tb_address_hit_counter_table.sv
`timescale 1ns / 1ps

module tb_address_hit_counter_table;

    localparam int N_RANDOM   = 700;
    localparam int N_HOT_BKT  = 8;
    localparam int TAGS_PER   = 6;
    localparam int N_HOT      = N_HOT_BKT * TAGS_PER;
    localparam int PAUSE_AT   = 350;
    localparam int HOLD_AT    = 200;
    localparam int HOLD_LEN   = 400;
    localparam int IDLE_LIMIT = 5000;
    localparam int PLAN_LEN   = 20;

    localparam logic [aht_pkg::ADDR_W-1:0] ADDR_ONES = '1;
    localparam aht_pkg::result_t NO_ENTRY = '0;

    typedef struct {
        logic                        cmd;
        logic [aht_pkg::ADDR_W-1:0]  addr;
        logic [aht_pkg::IDX_W-1:0]   idx;
        bit                          lit;
        aht_pkg::result_t            res;
    } plan_row_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    logic                         s_command;
    logic [aht_pkg::ADDR_W-1:0]   s_address;
    logic [aht_pkg::IDX_W-1:0]    s_slot_index;
    logic                         m_valid;
    logic                         m_ready;
    logic [aht_pkg::ADDR_W-1:0]   m_entry_address;
    logic [aht_pkg::COUNT_W-1:0]  m_entry_count;
    logic                         m_entry_valid;
    logic                         m_was_new;
    logic                         m_bucket_full;
    logic                         m_count_saturated;

    // Travels with the payload: a typed-in expectation overrides the prediction.
    bit                           tag_literal;
    aht_pkg::result_t             tag_result;

    bit                           tbl_valid [aht_pkg::SLOTS];
    logic [aht_pkg::ADDR_W-1:0]   tbl_addr  [aht_pkg::SLOTS];
    logic [aht_pkg::COUNT_W-1:0]  tbl_count [aht_pkg::SLOTS];

    aht_pkg::result_t             expected_hits [$];
    int                           mismatches;
    int                           idle_cycles;
    logic [aht_pkg::ADDR_W-1:0]   hot_addr [N_HOT];
    int                           hot_bucket [N_HOT_BKT];

    plan_row_t plan [PLAN_LEN] = '{
        '{aht_pkg::CMD_READ,  48'h0,             12'h000, 1'b1, NO_ENTRY},
        '{aht_pkg::CMD_READ,  ADDR_ONES,         12'hFFF, 1'b1, NO_ENTRY},
        '{aht_pkg::CMD_COUNT, 48'h0,             12'hFFF, 1'b1,
          '{48'h0, 32'd1, 1'b1, 1'b1, 1'b0, 1'b0}},
        '{aht_pkg::CMD_COUNT, 48'h0,             12'h000, 1'b0, NO_ENTRY},
        '{aht_pkg::CMD_COUNT, ADDR_ONES,         12'hFFF, 1'b1,
          '{ADDR_ONES, 32'd1, 1'b1, 1'b1, 1'b0, 1'b0}},
        '{aht_pkg::CMD_COUNT, 48'h400,           12'h000, 1'b0, NO_ENTRY},
        '{aht_pkg::CMD_COUNT, 48'h800,           12'h000, 1'b0, NO_ENTRY},
        '{aht_pkg::CMD_COUNT, 48'hC00,           12'h000, 1'b0, NO_ENTRY},
        '{aht_pkg::CMD_COUNT, 48'h1000,          12'h000, 1'b1,
          '{48'h0, 32'd0, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{aht_pkg::CMD_COUNT, 48'h800,           12'h000, 1'b0, NO_ENTRY},
        '{aht_pkg::CMD_READ,  48'h0,             12'h000, 1'b0, NO_ENTRY},
        '{aht_pkg::CMD_READ,  48'h0,             12'h002, 1'b0, NO_ENTRY},
        '{aht_pkg::CMD_READ,  48'h0,             12'hFFC, 1'b1,
          '{ADDR_ONES, 32'd1, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{aht_pkg::CMD_COUNT, 48'hAAAA_AAAA_AAAA, 12'h555, 1'b0, NO_ENTRY},
        '{aht_pkg::CMD_COUNT, 48'h5555_5555_5555, 12'hAAA, 1'b0, NO_ENTRY},
        '{aht_pkg::CMD_READ,  48'h5555_5555_5555, 12'hAA8, 1'b0, NO_ENTRY},
        '{aht_pkg::CMD_READ,  48'hAAAA_AAAA_AAAA, 12'h554, 1'b0, NO_ENTRY},
        '{aht_pkg::CMD_COUNT, 48'h8000_0000_0000, 12'h000, 1'b1,
          '{48'h0, 32'd0, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{aht_pkg::CMD_READ,  48'h0,             12'h003, 1'b0, NO_ENTRY},
        '{aht_pkg::CMD_COUNT, 48'h0,             12'h000, 1'b0, NO_ENTRY}
    };

    address_hit_counter_table i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_address         (s_address),
        .s_slot_index      (s_slot_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_entry_address   (m_entry_address),
        .m_entry_count     (m_entry_count),
        .m_entry_valid     (m_entry_valid),
        .m_was_new         (m_was_new),
        .m_bucket_full     (m_bucket_full),
        .m_count_saturated (m_count_saturated)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Look up or allocate the entry for a count, or fetch a slot for a read.
    function automatic aht_pkg::result_t update_hit_table(
            input logic cmd,
            input logic [aht_pkg::ADDR_W-1:0] addr,
            input logic [aht_pkg::IDX_W-1:0] idx);
        aht_pkg::result_t r;
        int      base;
        int      hit_way;
        int      free_way;
        int      s;
        r = '0;
        if (cmd == aht_pkg::CMD_READ) begin
            if (idx < aht_pkg::SLOTS && tbl_valid[idx]) begin
                r.addr      = tbl_addr[idx];
                r.count     = tbl_count[idx];
                r.valid     = 1'b1;
                r.saturated = (tbl_count[idx] == aht_pkg::COUNT_MAX);
            end
            return r;
        end
        base     = int'(addr % aht_pkg::BUCKETS) * aht_pkg::WAYS;
        hit_way  = -1;
        free_way = -1;
        for (int w = 0; w < aht_pkg::WAYS; w++) begin
            if (tbl_valid[base + w]) begin
                if (hit_way < 0 && tbl_addr[base + w] == addr)
                    hit_way = w;
            end else if (free_way < 0) begin
                free_way = w;
            end
        end
        if (hit_way < 0) begin
            if (free_way < 0) begin
                r.bucket_full = 1'b1;
                return r;
            end
            s = base + free_way;
            tbl_valid[s] = 1'b1;
            tbl_addr[s]  = addr;
            tbl_count[s] = '0;
            r.was_new    = 1'b1;
        end else begin
            s = base + hit_way;
        end
        if (tbl_count[s] == aht_pkg::COUNT_MAX)
            r.saturated = 1'b1;
        else
            tbl_count[s] = tbl_count[s] + 1'b1;
        r.addr  = addr;
        r.count = tbl_count[s];
        r.valid = 1'b1;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : scoreboard
        aht_pkg::result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                want = update_hit_table(s_command, s_address, s_slot_index);
                expected_hits.push_back(tag_literal ? tag_result : want);
            end
            if (m_valid && m_ready) begin
                if (expected_hits.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing expected", $time);
                end else begin
                    want = expected_hits.pop_front();
                    check_field("entry_address", 64'(want.addr), 64'(m_entry_address));
                    check_field("entry_count", 64'(want.count), 64'(m_entry_count));
                    check_field("entry_valid", 64'(want.valid), 64'(m_entry_valid));
                    check_field("was_new", 64'(want.was_new), 64'(m_was_new));
                    check_field("bucket_full", 64'(want.bucket_full), 64'(m_bucket_full));
                    check_field("count_saturated", 64'(want.saturated),
                                64'(m_count_saturated));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge aclk);
        $display("TEST FAILED");
        $finish;
    end

    // Result side: random back-pressure, one long hold-off, some bursts.
    initial begin
        int n_taken;
        int wait_cycles;
        n_taken = 0;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (n_taken == HOLD_AT)
                wait_cycles = HOLD_LEN;
            else if ((n_taken % 90) < 25)
                wait_cycles = 0;
            else
                wait_cycles = $urandom_range(0, 10);
            if (wait_cycles != 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            n_taken++;
        end
    end

    task automatic offer(input logic cmd, input logic [aht_pkg::ADDR_W-1:0] addr,
                         input logic [aht_pkg::IDX_W-1:0] idx, input bit lit,
                         input aht_pkg::result_t res, input int gap);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_command    <= cmd;
        s_address    <= addr;
        s_slot_index <= idx;
        tag_literal  <= lit;
        tag_result   <= res;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic [aht_pkg::ADDR_W-1:0] rand_addr();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[aht_pkg::ADDR_W-1:0];
    endfunction

    initial begin
        int                          gap;
        int                          pick;
        int                          bkt;
        logic                        cmd;
        logic [aht_pkg::ADDR_W-1:0]  addr;
        logic [aht_pkg::IDX_W-1:0]   idx;
        logic [aht_pkg::ADDR_W-1:0]  tag;

        for (int k = 0; k < aht_pkg::SLOTS; k++) begin
            tbl_valid[k] = 1'b0;
            tbl_addr[k]  = '0;
            tbl_count[k] = '0;
        end
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_command    <= aht_pkg::CMD_COUNT;
        s_address    <= '0;
        s_slot_index <= '0;
        tag_literal  <= 1'b0;
        tag_result   <= NO_ENTRY;

        // A few buckets take many tags each, so hits, allocations and drops all occur.
        hot_bucket[0] = 0;
        hot_bucket[1] = aht_pkg::BUCKETS - 1;
        for (int b = 2; b < N_HOT_BKT; b++)
            hot_bucket[b] = $urandom_range(0, aht_pkg::BUCKETS - 1);
        for (int h = 0; h < N_HOT; h++) begin
            tag = rand_addr();
            hot_addr[h] = aht_pkg::ADDR_W'((tag / aht_pkg::BUCKETS) * aht_pkg::BUCKETS
                        + hot_bucket[h % N_HOT_BKT]);
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i])
            offer(plan[i].cmd, plan[i].addr, plan[i].idx, plan[i].lit, plan[i].res,
                  $urandom_range(0, 10));

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == PAUSE_AT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (expected_hits.size() != 0) @(posedge aclk);
            end
            pick = $urandom_range(0, 99);
            addr = rand_addr();
            idx  = aht_pkg::IDX_W'($urandom);
            if (pick < 20) begin
                cmd = aht_pkg::CMD_READ;
                if (pick < 12) begin
                    bkt = hot_bucket[$urandom_range(0, N_HOT_BKT - 1)];
                    idx = aht_pkg::IDX_W'(bkt * aht_pkg::WAYS
                        + $urandom_range(0, aht_pkg::WAYS - 1));
                end
            end else begin
                cmd = aht_pkg::CMD_COUNT;
                if (pick < 90)
                    addr = hot_addr[$urandom_range(0, N_HOT - 1)];
            end
            gap = ((n % 100) < 30) ? 0 : $urandom_range(0, 10);
            offer(cmd, addr, idx, 1'b0, NO_ENTRY, gap);
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_hits.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && expected_hits.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
